[rtl/core/rk4r_pkg.sv]
// Shared types, constants, saturation helpers and the step microprogram.
package rk4r_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 24;

  // Width of configuration time values and of data words.
  localparam int TIME_W = 31;
  localparam int DATA_W = 32;

  // Iterative divider geometry: two quotient bits per cycle.
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = 5;

  // Program counter width of the microprogram.
  localparam int PC_W = 5;

  // Signed 32-bit range, held at 64 bits for comparison.
  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

  // Operation of one microinstruction.
  typedef enum logic [1:0] {
    OP_MUL,
    OP_SHF,
    OP_ADD,
    OP_DIV
  } op_t;

  // Operand and destination registers of the shared unit.
  typedef enum logic [2:0] {
    R_Y,
    R_H,
    R_K1,
    R_K2,
    R_K3,
    R_K4,
    R_TMP,
    R_ONE
  } reg_t;

  // Product shift: by the fraction bits, or one more for a half step.
  typedef enum logic {
    SH_F,
    SH_F1
  } shf_t;

  typedef struct packed {
    op_t  op;
    reg_t a;
    reg_t b;
    reg_t dst;
    shf_t sh;
    logic last;
  } uop_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic load_h;
    logic exec;
    logic wr_q;
    uop_t uop;
  } dp_ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic same;
    logic ovf;
  } dp_stat_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < S32_MIN) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // True when sat32 would clamp the value.
  function automatic logic sat_hit(input logic signed [63:0] v);
    return (v > S32_MAX) || (v < S32_MIN);
  endfunction

  function automatic uop_t mk(input op_t op, input reg_t a, input reg_t b,
                              input reg_t dst, input shf_t sh, input logic last);
    uop_t u;
    u.op   = op;
    u.a    = a;
    u.b    = b;
    u.dst  = dst;
    u.sh   = sh;
    u.last = last;
    return u;
  endfunction

  // One RK4 step as a sequence of operations on the shared unit.
  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    case (pc)
      // k1 = 1 + y^2
      5'd0:  return mk(OP_MUL, R_Y,   R_Y,   R_TMP, SH_F,  1'b0);
      5'd1:  return mk(OP_SHF, R_Y,   R_Y,   R_TMP, SH_F,  1'b0);
      5'd2:  return mk(OP_ADD, R_ONE, R_TMP, R_K1,  SH_F,  1'b0);
      // k2 = slope(y + (h/2)k1)
      5'd3:  return mk(OP_MUL, R_H,   R_K1,  R_TMP, SH_F,  1'b0);
      5'd4:  return mk(OP_SHF, R_Y,   R_Y,   R_TMP, SH_F1, 1'b0);
      5'd5:  return mk(OP_ADD, R_Y,   R_TMP, R_TMP, SH_F,  1'b0);
      5'd6:  return mk(OP_MUL, R_TMP, R_TMP, R_TMP, SH_F,  1'b0);
      5'd7:  return mk(OP_SHF, R_Y,   R_Y,   R_TMP, SH_F,  1'b0);
      5'd8:  return mk(OP_ADD, R_ONE, R_TMP, R_K2,  SH_F,  1'b0);
      // k3 = slope(y + (h/2)k2)
      5'd9:  return mk(OP_MUL, R_H,   R_K2,  R_TMP, SH_F,  1'b0);
      5'd10: return mk(OP_SHF, R_Y,   R_Y,   R_TMP, SH_F1, 1'b0);
      5'd11: return mk(OP_ADD, R_Y,   R_TMP, R_TMP, SH_F,  1'b0);
      5'd12: return mk(OP_MUL, R_TMP, R_TMP, R_TMP, SH_F,  1'b0);
      5'd13: return mk(OP_SHF, R_Y,   R_Y,   R_TMP, SH_F,  1'b0);
      5'd14: return mk(OP_ADD, R_ONE, R_TMP, R_K3,  SH_F,  1'b0);
      // k4 = slope(y + h*k3)
      5'd15: return mk(OP_MUL, R_H,   R_K3,  R_TMP, SH_F,  1'b0);
      5'd16: return mk(OP_SHF, R_Y,   R_Y,   R_TMP, SH_F,  1'b0);
      5'd17: return mk(OP_ADD, R_Y,   R_TMP, R_TMP, SH_F,  1'b0);
      5'd18: return mk(OP_MUL, R_TMP, R_TMP, R_TMP, SH_F,  1'b0);
      5'd19: return mk(OP_SHF, R_Y,   R_Y,   R_TMP, SH_F,  1'b0);
      5'd20: return mk(OP_ADD, R_ONE, R_TMP, R_K4,  SH_F,  1'b0);
      // Slope sum k1 + k4 + 2(k2 + k3)
      5'd21: return mk(OP_ADD, R_K2,  R_K3,  R_K2,  SH_F,  1'b0);
      5'd22: return mk(OP_ADD, R_K1,  R_K4,  R_K1,  SH_F,  1'b0);
      5'd23: return mk(OP_ADD, R_K2,  R_K2,  R_K2,  SH_F,  1'b0);
      5'd24: return mk(OP_ADD, R_K1,  R_K2,  R_TMP, SH_F,  1'b0);
      // Update: y + sum*h / 6
      5'd25: return mk(OP_MUL, R_TMP, R_H,   R_TMP, SH_F,  1'b0);
      5'd26: return mk(OP_DIV, R_Y,   R_Y,   R_TMP, SH_F,  1'b0);
      5'd27: return mk(OP_ADD, R_Y,   R_TMP, R_Y,   SH_F,  1'b1);
      default: return mk(OP_ADD, R_ONE, R_ONE, R_ONE, SH_F, 1'b1);
    endcase
  endfunction

endpackage

[rtl/core/rk4_riccati_integrator.sv]
// Top level: APB registers, step sequencer, shared datapath and remainder divider.
// Each accepted start runs a series of steps until done; a step is the check state, the
// microprogram and the wait state for the division by six.
// A full step that leaves y unchanged adds a remainder pass that skips idle steps.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// Synchronous active-high reset restores the register defaults; the result port has no stall.
module rk4_riccati_integrator
  import rk4r_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] initial_value,
  output logic               done,
  output logic signed [31:0] final_value,
  output logic               saturated
);

  localparam logic [TIME_W-1:0]    END_RST  = 31'd16777216;
  localparam logic [TIME_W-1:0]    STEP_RST = 31'd16777;

  typedef enum logic [1:0] {
    REG_START,
    REG_END,
    REG_STEP,
    REG_NONE
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_DIVW,
    S_MODS,
    S_MODW
  } state_t;

  state_t            state;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;
  logic [TIME_W-1:0] step_size;
  logic [TIME_W-1:0] t;
  logic [TIME_W-1:0] hs;
  logic              full;
  logic [PC_W-1:0]   pc;
  logic              q_wait;

  reg_idx_t              idx;
  uop_t                  uop;
  dp_ctrl_t              ctrl;
  dp_stat_t              stat;
  logic signed [31:0]    y;
  logic                  finish;
  logic                  over;
  logic [TIME_W-1:0]     hs_sel;
  logic [TIME_W-1:0]     remain;
  logic                  div_start;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DIV_DEN_W-1:0]  div_den;
  logic                  div_done;
  logic [DIV_DEN_W-1:0]  rem;

  // Configuration registers.
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
      end_time   <= END_RST;
      step_size  <= STEP_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_START: start_time <= pwdata[TIME_W-1:0];
        REG_END:   end_time   <= pwdata[TIME_W-1:0];
        REG_STEP:  step_size  <= pwdata[TIME_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START: prdata = {1'b0, start_time};
      REG_END:   prdata = {1'b0, end_time};
      REG_STEP:  prdata = {1'b0, step_size};
      default:   prdata = '0;
    endcase
  end

  // Step length: the nominal step, clipped to land on the end time.
  always_comb begin
    finish = (step_size == '0) || (t >= end_time);
    over   = ({1'b0, t} + {1'b0, step_size}) > {1'b0, end_time};
    hs_sel = over ? TIME_W'(end_time - t) : step_size;
    remain = TIME_W'(end_time - t);
    uop    = uop_at(pc);
  end

  // Datapath and divider controls.
  always_comb begin
    ctrl.load   = (state == S_IDLE) && start;
    ctrl.load_h = (state == S_CHECK) && !finish;
    ctrl.exec   = (state == S_RUN) && (uop.op != OP_DIV);
    ctrl.wr_q   = (state == S_DIVW) && !q_wait;
    ctrl.uop    = uop;
    div_start   = (state == S_MODS);
    div_num     = {{(DIV_NUM_W-TIME_W){1'b0}}, remain};
    div_den     = {1'b0, hs};
  end

  // Step sequencer with the registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            t     <= start_time;
            busy  <= 1'b1;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (finish) begin
            done        <= 1'b1;
            final_value <= y;
            saturated   <= stat.ovf;
            busy        <= 1'b0;
            state       <= S_IDLE;
          end else begin
            hs    <= hs_sel;
            full  <= !over;
            pc    <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (uop.op == OP_DIV) begin
            q_wait <= 1'b1;
            state  <= S_DIVW;
          end else if (uop.last) begin
            t <= t + hs;
            if (full && stat.same) begin
              state <= S_MODS;
            end else begin
              state <= S_CHECK;
            end
          end else begin
            pc <= pc + 1'b1;
          end
        end
        S_DIVW: begin
          // Wait here until the pipeline of the division by six holds the quotient, then write it.
          if (q_wait) begin
            q_wait <= 1'b0;
          end else begin
            pc    <= pc + 1'b1;
            state <= S_RUN;
          end
        end
        S_MODS: begin
          state <= S_MODW;
        end
        S_MODW: begin
          // Skip every further full step; only the leftover partial step, if any, remains.
          if (div_done) begin
            t     <= TIME_W'(end_time - rem[TIME_W-1:0]);
            state <= S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  rk4r_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .init_value (initial_value),
    .hs         (hs_sel),
    .y          (y),
    .stat       (stat)
  );

  rk4r_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .remainder (rem)
  );

endmodule

[rtl/core/rk4r_div.sv]
// Iterative restoring divider that returns the remainder, two bits per cycle.
module rk4r_div
  import rk4r_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] dividend,
  input  logic [DIV_DEN_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_DEN_W-1:0] remainder
);

  logic [DIV_NUM_W-1:0] num;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 run;

  logic [DIV_DEN_W:0]   t1;
  logic [DIV_DEN_W:0]   t2;
  logic                 g1;
  logic                 g2;
  logic [DIV_DEN_W-1:0] r1;
  logic [DIV_DEN_W-1:0] r2;

  // Two dependent restoring steps; the partial remainder stays below the divisor.
  always_comb begin
    t1 = {rem, num[DIV_NUM_W-1]};
    g1 = t1 >= {1'b0, den};
    r1 = g1 ? DIV_DEN_W'(t1 - {1'b0, den}) : t1[DIV_DEN_W-1:0];
    t2 = {r1, num[DIV_NUM_W-2]};
    g2 = t2 >= {1'b0, den};
    r2 = g2 ? DIV_DEN_W'(t2 - {1'b0, den}) : t2[DIV_DEN_W-1:0];
  end

  // Quotient bits shift in as dividend bits shift out.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num <= dividend;
        den <= divisor;
        rem <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        num <= {num[DIV_NUM_W-3:0], g1, g2};
        rem <= r2;
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem;

endmodule

[rtl/core/rk4r_dp.sv]
// Register file and shared multiply, shift-saturate and add unit.
module rk4r_dp
  import rk4r_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_ctrl_t             ctrl,
  input  logic signed [31:0]   init_value,
  input  logic [TIME_W-1:0]    hs,
  output logic signed [31:0]   y,
  output dp_stat_t             stat
);

  localparam logic signed [31:0] ONE = 32'sh1 << FRAC_BITS;

  // Reciprocals of three: ceil(2^18 / 3) and ceil(2^23 / 3).
  localparam logic [16:0] RCP3_HI = 17'd87382;
  localparam logic [21:0] RCP3_LO = 22'd2796203;

  logic signed [31:0] y_r;
  logic signed [31:0] h_r;
  logic signed [31:0] k1;
  logic signed [31:0] k2;
  logic signed [31:0] k3;
  logic signed [31:0] k4;
  logic signed [31:0] tmp;
  logic signed [63:0] p_r;
  logic               ovf;

  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [63:0] mul_w;
  logic signed [63:0] add_w;
  logic signed [63:0] shf_w;
  logic signed [63:0] pre_w;
  logic signed [31:0] res;
  logic               res_ovf;
  logic signed [63:0] qs;
  logic [63:0]        mag;
  logic [63:0]        div_arg;

  logic               d6_big;
  logic [16:0]        d6_hi;
  logic [33:0]        d6_hp;
  logic [15:0]        d6_qh;
  logic [16:0]        d6_q3;
  logic [16:0]        d6_rs;
  logic [43:0]        d6_lp;
  logic [20:0]        d6_ql;
  logic [35:0]        d6_sum;
  logic               big_r;
  logic [15:0]        qh_r;
  logic [21:0]        v_r;
  logic [35:0]        q_r;

  function automatic logic signed [31:0] rd(input reg_t r, input logic signed [31:0] yv,
                                            input logic signed [31:0] hv,
                                            input logic signed [31:0] v1,
                                            input logic signed [31:0] v2,
                                            input logic signed [31:0] v3,
                                            input logic signed [31:0] v4,
                                            input logic signed [31:0] tv);
    case (r)
      R_Y:     return yv;
      R_H:     return hv;
      R_K1:    return v1;
      R_K2:    return v2;
      R_K3:    return v3;
      R_K4:    return v4;
      R_TMP:   return tv;
      default: return ONE;
    endcase
  endfunction

  // Operand selection and the shared arithmetic.
  always_comb begin
    opa     = rd(ctrl.uop.a, y_r, h_r, k1, k2, k3, k4, tmp);
    opb     = rd(ctrl.uop.b, y_r, h_r, k1, k2, k3, k4, tmp);
    mul_w   = opa * opb;
    add_w   = 64'(opa) + 64'(opb);
    shf_w   = (ctrl.uop.sh == SH_F1) ? (p_r >>> (FRAC_BITS + 1)) : (p_r >>> FRAC_BITS);
    pre_w   = (ctrl.uop.op == OP_ADD) ? add_w : shf_w;
    res     = sat32(pre_w);
    res_ovf = sat_hit(pre_w);
  end

  // The update divides |sum*h| >> FRAC_BITS by six; the sign comes back afterwards.
  // The value is halved, then split into a high and a low part that are each divided
  // by three with a reciprocal multiplication, one pipeline stage per part.
  // Anything at or above 2^38 is far beyond the saturation limit after the division.
  always_comb begin
    mag     = p_r[63] ? 64'(-p_r) : 64'(p_r);
    div_arg = mag >> FRAC_BITS;
    d6_big  = |div_arg[63:38];
    d6_hi   = div_arg[37:21];
    d6_hp   = d6_hi * RCP3_HI;
    d6_qh   = d6_hp[33:18];
    d6_q3   = {d6_qh, 1'b0} + {1'b0, d6_qh};
    d6_rs   = d6_hi - d6_q3;
    d6_lp   = v_r * RCP3_LO;
    d6_ql   = d6_lp[43:23];
    d6_sum  = {qh_r, 20'd0} + {15'd0, d6_ql};
    qs      = p_r[63] ? -$signed(64'(q_r)) : $signed(64'(q_r));
  end

  // Pipeline registers of the division by six.
  always_ff @(posedge clk) begin
    big_r <= d6_big;
    qh_r  <= d6_qh;
    v_r   <= {d6_rs[1:0], div_arg[20:1]};
    q_r   <= big_r ? '1 : d6_sum;
  end

  // Register file writes.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      y_r <= init_value;
    end
    if (ctrl.load_h) begin
      h_r <= $signed({1'b0, hs});
    end
    if (ctrl.exec) begin
      if (ctrl.uop.op == OP_MUL) begin
        p_r <= mul_w;
      end else begin
        case (ctrl.uop.dst)
          R_Y:     y_r <= res;
          R_K1:    k1  <= res;
          R_K2:    k2  <= res;
          R_K3:    k3  <= res;
          R_K4:    k4  <= res;
          R_TMP:   tmp <= res;
          default: ;
        endcase
      end
    end
    if (ctrl.wr_q) begin
      tmp <= sat32(qs);
    end
  end

  // Sticky saturation flag, cleared for each new transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf <= 1'b0;
    end else if (ctrl.load) begin
      ovf <= 1'b0;
    end else if (ctrl.exec && (ctrl.uop.op != OP_MUL) && res_ovf) begin
      ovf <= 1'b1;
    end else if (ctrl.wr_q && sat_hit(qs)) begin
      ovf <= 1'b1;
    end
  end

  assign y         = y_r;
  assign stat.same = (res == y_r);
  assign stat.ovf  = ovf;

endmodule

[bench/rk4_riccati_integrator_test.sv]
// Self-checking testbench for the RK4 Riccati integrator with its APB register port.
`timescale 1ns / 100ps

module rk4_riccati_integrator_test;

  localparam int FB = rk4r_pkg::FRAC_BITS_DEF;
  localparam int FX_ONE = 1 << FB;
  localparam int unsigned TIME_MAX = 32'h7FFF_FFFF;
  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int IDLE_PCT = 17;
  localparam int PRINT_CAP = 40;

  // Register map, one word per register.
  typedef enum logic [1:0] {
    REG_START_TIME,
    REG_END_TIME,
    REG_STEP_SIZE
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_RUN,
    CMD_REG_WRITE,
    CMD_SETTLE
  } cmd_kind_t;

  typedef struct {
    cmd_kind_t   kind;
    cfg_reg_t    reg_idx;
    logic [31:0] data;
    bit          steady;
  } bench_cmd_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } outcome_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] initial_value = '0;
  logic               done;
  logic signed [31:0] final_value;
  logic               saturated;

  // Copy of the configuration as the block should hold it.
  int unsigned cfg_start = 32'd0;
  int unsigned cfg_end = 32'd16777216;
  int unsigned cfg_step = 32'd16777;

  bench_cmd_t cmd_q[$];
  outcome_t   pending_outcomes[$];
  bit         settling = 1'b0;
  int         settle_left = 0;
  bit         sat_seen;
  int         mismatches = 0;
  int         runs_sent = 0;
  int         results_seen = 0;
  int         saturated_runs = 0;
  int         windows = 0;
  int unsigned cycle_count = 0;

  rk4_riccati_integrator u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .initial_value(initial_value),
    .done         (done),
    .final_value  (final_value),
    .saturated    (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Fixed-point arithmetic of the integrator; any clamp marks the run as saturated.
  function automatic int sat_word(input longint v);
    if (v > S_MAX) begin
      sat_seen = 1'b1;
      return int'(S_MAX);
    end
    if (v < S_MIN) begin
      sat_seen = 1'b1;
      return int'(S_MIN);
    end
    return int'(v);
  endfunction

  function automatic int fx_mul(input int a, input int b, input int sh);
    longint p;
    p = longint'(a) * longint'(b);
    return sat_word(p >>> sh);
  endfunction

  function automatic int fx_add(input int a, input int b);
    return sat_word(longint'(a) + longint'(b));
  endfunction

  function automatic int riccati_slope(input int y);
    return fx_add(FX_ONE, fx_mul(y, y, FB));
  endfunction

  // One classic RK4 step; the final division by six truncates toward zero.
  function automatic int rk4_advance(input int y, input int h);
    int k1, k2, k3, k4, mid, total;
    longint quo;
    k1 = riccati_slope(y);
    k2 = riccati_slope(fx_add(y, fx_mul(h, k1, FB + 1)));
    k3 = riccati_slope(fx_add(y, fx_mul(h, k2, FB + 1)));
    k4 = riccati_slope(fx_add(y, fx_mul(h, k3, FB)));
    mid = fx_add(k2, k3);
    total = fx_add(fx_add(k1, k4), fx_add(mid, mid));
    quo = (longint'(total) * longint'(h)) / (longint'(6) <<< FB);
    return fx_add(y, sat_word(quo));
  endfunction

  // Integrates from t0 to t1, clipping the last step and skipping over a stalled value.
  function automatic outcome_t integrate_riccati(input int y0, input int unsigned t0,
                                                 input int unsigned t1, input int unsigned h);
    outcome_t r;
    longint   t, t_end, hs;
    int       y, prior;
    bit       full;
    sat_seen = 1'b0;
    y = y0;
    t = longint'(t0);
    t_end = longint'(t1);
    if (h != 0) begin
      while (t < t_end) begin
        hs = longint'(h);
        full = 1'b1;
        prior = y;
        if (t + hs > t_end) begin
          hs = t_end - t;
          full = 1'b0;
        end
        y = rk4_advance(y, int'(hs));
        t = t + hs;
        if (full && y == prior) begin
          t = t + ((t_end - t) / hs) * hs;
        end
      end
    end
    r.value = y;
    r.sat = sat_seen;
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    end
    mismatches++;
  endtask

  // Driver: runs the command queue, one APB write or one start transaction at a time.
  always @(posedge clk) begin
    logic               n_start, n_psel, n_penable, n_pwrite;
    logic [3:0]         n_paddr;
    logic [31:0]        n_pwdata;
    logic signed [31:0] n_value;
    bit                 free;
    bench_cmd_t         c;
    n_start = start;
    n_psel = psel;
    n_penable = penable;
    n_pwrite = pwrite;
    n_paddr = paddr;
    n_pwdata = pwdata;
    n_value = initial_value;
    free = 1'b1;
    if (rst) begin
      n_start = 1'b0;
      n_psel = 1'b0;
      n_penable = 1'b0;
      n_pwrite = 1'b0;
      n_paddr = '0;
      n_pwdata = '0;
      n_value = '0;
      settling = 1'b0;
      free = 1'b0;
    end else begin
      // A start transaction is taken when busy is low; predict its result right away.
      if (start) begin
        if (!busy) begin
          pending_outcomes.push_back(
            integrate_riccati(initial_value, cfg_start, cfg_end, cfg_step));
          runs_sent++;
          n_start = 1'b0;
        end else begin
          free = 1'b0;
        end
      end
      // APB write: setup cycle, then access cycle; pready is always high.
      if (psel && !penable) begin
        n_penable = 1'b1;
        free = 1'b0;
      end else if (psel && penable) begin
        case (cfg_reg_t'(paddr[3:2]))
          REG_START_TIME: cfg_start = pwdata[30:0];
          REG_END_TIME:   cfg_end = pwdata[30:0];
          REG_STEP_SIZE:  cfg_step = pwdata[30:0];
          default: ;
        endcase
        n_psel = 1'b0;
        n_penable = 1'b0;
        n_pwrite = 1'b0;
      end
      // A pause holds the sender until every result is back and the settle count runs out.
      if (settling) begin
        free = 1'b0;
        if (pending_outcomes.size() == 0) begin
          if (settle_left == 0) begin
            settling = 1'b0;
          end else begin
            settle_left--;
          end
        end
      end
      if (free && cmd_q.size() != 0) begin
        c = cmd_q[0];
        case (c.kind)
          CMD_RUN: begin
            if (c.steady || $urandom_range(99) >= IDLE_PCT) begin
              void'(cmd_q.pop_front());
              n_start = 1'b1;
              n_value = c.data;
            end
          end
          CMD_REG_WRITE: begin
            void'(cmd_q.pop_front());
            n_psel = 1'b1;
            n_penable = 1'b0;
            n_pwrite = 1'b1;
            n_paddr = {c.reg_idx, 2'b00};
            n_pwdata = c.data;
          end
          CMD_SETTLE: begin
            void'(cmd_q.pop_front());
            settling = 1'b1;
            settle_left = SETTLE_CYCLES;
          end
          default: ;
        endcase
      end
    end
    start <= n_start;
    psel <= n_psel;
    penable <= n_penable;
    pwrite <= n_pwrite;
    paddr <= n_paddr;
    pwdata <= n_pwdata;
    initial_value <= n_value;
  end

  // Monitor: every result strobe is checked against the oldest prediction.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        log_mismatch($sformatf("result %h/%b with no transaction outstanding",
                               final_value, saturated));
      end else begin
        want = pending_outcomes.pop_front();
        results_seen++;
        if (want.sat) begin
          saturated_runs++;
        end
        if (final_value !== want.value) begin
          log_mismatch($sformatf("run %0d final_value %h, expected %h",
                                 results_seen, final_value, want.value));
        end
        if (saturated !== want.sat) begin
          log_mismatch($sformatf("run %0d saturated %b, expected %b",
                                 results_seen, saturated, want.sat));
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_outcomes.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_run(input logic [31:0] y0, input bit steady = 1'b0);
    bench_cmd_t c;
    c.kind = CMD_RUN;
    c.reg_idx = REG_START_TIME;
    c.data = y0;
    c.steady = steady;
    cmd_q.push_back(c);
  endtask

  task automatic add_pause();
    bench_cmd_t c;
    c.kind = CMD_SETTLE;
    c.reg_idx = REG_START_TIME;
    c.data = '0;
    c.steady = 1'b0;
    cmd_q.push_back(c);
  endtask

  // The top data bit lies outside the 31-bit registers, so it is driven at random.
  task automatic add_reg_write(input cfg_reg_t idx, input int unsigned value);
    bench_cmd_t c;
    c.kind = CMD_REG_WRITE;
    c.reg_idx = idx;
    c.data = {1'($urandom_range(1)), value[30:0]};
    c.steady = 1'b0;
    cmd_q.push_back(c);
  endtask

  // New integration window, written only once the block has gone idle.
  task automatic set_window(input int unsigned t0, input int unsigned t1,
                            input int unsigned h);
    add_pause();
    add_reg_write(REG_START_TIME, t0);
    add_reg_write(REG_END_TIME, t1);
    add_reg_write(REG_STEP_SIZE, h);
    windows++;
  endtask

  // Random window with at most about twenty steps, step sizes spread over all scales.
  task automatic add_random_window();
    int unsigned h, st;
    longint      span, nsteps;
    h = $urandom_range(TIME_MAX, 1) >> $urandom_range(30, 0);
    if (h == 0) begin
      h = 1;
    end
    nsteps = $urandom_range(20, 0);
    span = longint'(h) * nsteps + longint'($urandom % h);
    if (span > longint'(TIME_MAX)) begin
      span = longint'(TIME_MAX);
    end
    st = $urandom_range(int'(longint'(TIME_MAX) - span), 0);
    if ($urandom_range(5) == 0) begin
      set_window(st + int'(span), st, h);
    end else begin
      set_window(st, st + int'(span), h);
    end
  endtask

  // Mostly moderate starting values, plus raw bit patterns and the extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(32'h0800_0000, 0) - 32'h0400_0000;
    endcase
  endfunction

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: one time unit at the nominal step, mild and blowing-up starts.
    add_run(32'h0000_0000);
    add_run(32'h0100_0000);

    // Eight steps over one time unit with the extremes of the starting value.
    set_window(32'h0000_0000, 32'h0100_0000, 32'h0020_0000);
    add_run(32'h7FFF_FFFF);
    add_run(32'h8000_0000);
    add_run(32'h8000_0001);
    add_run(32'hFFFF_FFFF);
    add_run(32'h0000_0001);
    add_run(32'h0000_0000);
    add_run(32'hFF00_0000);
    add_run(32'h0080_0000);

    // Start equal to end, and start after end: the value passes through.
    set_window(32'h0500_0000, 32'h0500_0000, 32'h0020_0000);
    add_run(32'h1234_5678);
    set_window(TIME_MAX, 32'h0000_0000, TIME_MAX);
    add_run(32'hDEAD_BEEF);

    // Zero step size: no step is taken.
    set_window(32'h0000_0000, 32'h0100_0000, 32'h0000_0000);
    add_run(32'h0300_0000);

    // Largest step over the widest window.
    set_window(32'h0000_0000, TIME_MAX, TIME_MAX);
    add_run(32'h0000_0000);
    add_run(32'hFF80_0000);

    // A saturated value stalls, so time jumps ahead before a clipped final step.
    set_window(32'h0000_0000, 32'h0100_0000, 32'h0000_0003);
    add_run(32'h7FFF_FFFF);

    // Two full steps and a clipped one from a nonzero start time.
    set_window(32'h0100_0000, 32'h014C_CCCC, 32'h0020_0000);
    add_run(32'h0040_0000);

    // Random windows with random starting values; one phase runs with no idle cycles.
    for (int p = 0; p < 8; p++) begin
      add_random_window();
      for (n = 0; n < 12; n++) begin
        add_run(pick_value(), p == 3);
        if (p == 5 && n == 5) begin
          add_pause();
        end
      end
    end

    // Back to the reset-time window for a last check.
    set_window(32'h0000_0000, 32'h0100_0000, 32'd16777);
    add_run(32'hFFC0_0000);

    // Wait for the queue to empty and every result to come back.
    @(negedge clk);
    while (cmd_q.size() != 0 || start || settling || pending_outcomes.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d transactions over %0d register windows; %0d results checked.",
             runs_sent, windows, results_seen);
    $display("%0d results saturated; %0d mismatches in %0d cycles.",
             saturated_runs, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
